### rtl/sct_pkg.sv
`default_nettype none
package sct_pkg;

	// Default sizes of the position counter and the number accumulator.
	localparam int unsigned POSITION_BITS_DEF = 16;
	localparam int unsigned MANTISSA_BITS_DEF = 32;

	localparam int unsigned KIND_BITS = 7;
	localparam int unsigned ERR_BITS  = 3;
	localparam int unsigned FRAC_BITS = 4;
	localparam int unsigned NUM_KW    = 21;
	localparam int unsigned KW_CHARS  = 11;

	// Token kinds.
	localparam logic [KIND_BITS-1:0] K_INTEGER    = 7'd0;
	localparam logic [KIND_BITS-1:0] K_FLOAT      = 7'd1;
	localparam logic [KIND_BITS-1:0] K_IDENT      = 7'd2;
	localparam logic [KIND_BITS-1:0] K_CHAR       = 7'd3;
	localparam logic [KIND_BITS-1:0] K_STRING     = 7'd4;
	localparam logic [KIND_BITS-1:0] K_KW0        = 7'd5;
	localparam logic [KIND_BITS-1:0] K_PLUS       = 7'd26;
	localparam logic [KIND_BITS-1:0] K_MINUS      = 7'd29;
	localparam logic [KIND_BITS-1:0] K_STAR       = 7'd32;
	localparam logic [KIND_BITS-1:0] K_DSTAR      = 7'd34;
	localparam logic [KIND_BITS-1:0] K_DSTAR_EQ   = 7'd35;
	localparam logic [KIND_BITS-1:0] K_SLASH      = 7'd36;
	localparam logic [KIND_BITS-1:0] K_MODULO     = 7'd38;
	localparam logic [KIND_BITS-1:0] K_EQUAL      = 7'd40;
	localparam logic [KIND_BITS-1:0] K_BANG       = 7'd42;
	localparam logic [KIND_BITS-1:0] K_LESS       = 7'd44;
	localparam logic [KIND_BITS-1:0] K_GREATER    = 7'd46;
	localparam logic [KIND_BITS-1:0] K_LPAREN     = 7'd48;
	localparam logic [KIND_BITS-1:0] K_RPAREN     = 7'd49;
	localparam logic [KIND_BITS-1:0] K_LBRACE     = 7'd50;
	localparam logic [KIND_BITS-1:0] K_RBRACE     = 7'd51;
	localparam logic [KIND_BITS-1:0] K_LBRACKET   = 7'd52;
	localparam logic [KIND_BITS-1:0] K_RBRACKET   = 7'd53;
	localparam logic [KIND_BITS-1:0] K_SEMI       = 7'd54;
	localparam logic [KIND_BITS-1:0] K_DOT        = 7'd55;
	localparam logic [KIND_BITS-1:0] K_COMMA      = 7'd56;
	localparam logic [KIND_BITS-1:0] K_DAMP       = 7'd57;
	localparam logic [KIND_BITS-1:0] K_DPIPE      = 7'd58;
	localparam logic [KIND_BITS-1:0] K_QUESTION   = 7'd59;
	localparam logic [KIND_BITS-1:0] K_HASH       = 7'd60;
	localparam logic [KIND_BITS-1:0] K_COLON      = 7'd61;
	localparam logic [KIND_BITS-1:0] K_AT         = 7'd62;
	localparam logic [KIND_BITS-1:0] K_UNDERSCORE = 7'd63;
	localparam logic [KIND_BITS-1:0] K_EOF        = 7'd64;

	// Error codes.
	localparam logic [ERR_BITS-1:0] E_NONE       = 3'd0;
	localparam logic [ERR_BITS-1:0] E_UNKNOWN    = 3'd1;
	localparam logic [ERR_BITS-1:0] E_LONE_AMP   = 3'd2;
	localparam logic [ERR_BITS-1:0] E_LONE_PIPE  = 3'd3;
	localparam logic [ERR_BITS-1:0] E_CHAR_OPEN  = 3'd4;
	localparam logic [ERR_BITS-1:0] E_CHAR_BODY  = 3'd5;
	localparam logic [ERR_BITS-1:0] E_CHAR_CLOSE = 3'd6;
	localparam logic [ERR_BITS-1:0] E_STRING     = 3'd7;

	// Byte codes with a role of their own.
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_PIPE   = 8'h7C;
	localparam logic [7:0] CH_EQUAL  = 8'h3D;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;

	// Keyword spellings, padded to eleven bytes, first byte leftmost.
	localparam logic [8*KW_CHARS-1:0] KW_STR [NUM_KW] = '{
		"abstract   ", "break      ", "class      ", "const      ",
		"constructor", "continue   ", "do         ", "else       ",
		"enum       ", "false      ", "if         ", "interface  ",
		"loop       ", "match      ", "new        ", "null       ",
		"return     ", "static     ", "true       ", "var        ",
		"while      "
	};
	localparam logic [3:0] KW_LEN [NUM_KW] = '{
		4'd8, 4'd5, 4'd5, 4'd5, 4'd11, 4'd8, 4'd2, 4'd4, 4'd4, 4'd5, 4'd2,
		4'd9, 4'd4, 4'd5, 4'd3, 4'd4, 4'd6, 4'd6, 4'd4, 4'd3, 4'd5
	};

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == " ") || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
	endfunction

	// Operator bytes that may combine with the next byte.
	function automatic logic is_op(input logic [7:0] c);
		case (c)
			"+", "-", "*", "/", "%", "=", "!", "<", ">", "&", "|": return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic [KIND_BITS-1:0] op_base(input logic [7:0] c);
		case (c)
			"+": return K_PLUS;
			"-": return K_MINUS;
			"*": return K_STAR;
			"/": return K_SLASH;
			"%": return K_MODULO;
			"=": return K_EQUAL;
			"!": return K_BANG;
			"<": return K_LESS;
			">": return K_GREATER;
			"&": return K_DAMP;
			default: return K_DPIPE;
		endcase
	endfunction

	// Kind of a one-byte token; EOF marks a byte that is no token at all.
	function automatic logic [KIND_BITS-1:0] single_kind(input logic [7:0] c);
		case (c)
			"(": return K_LPAREN;
			")": return K_RPAREN;
			"{": return K_LBRACE;
			"}": return K_RBRACE;
			"[": return K_LBRACKET;
			"]": return K_RBRACKET;
			";": return K_SEMI;
			",": return K_COMMA;
			"?": return K_QUESTION;
			"#": return K_HASH;
			":": return K_COLON;
			"@": return K_AT;
			"_": return K_UNDERSCORE;
			default: return K_EOF;
		endcase
	endfunction

	// Drops the keywords whose byte at this place differs from c.
	function automatic logic [NUM_KW-1:0] word_add(input logic [NUM_KW-1:0] cand,
			input logic [3:0] idx, input logic [7:0] c);
		logic [NUM_KW-1:0] r;
		logic [7:0] kc;
		r = cand;
		for (int i = 0; i < NUM_KW; i++) begin
			kc = 8'h00;
			if (idx < KW_LEN[i])
				kc = KW_STR[i][8*(KW_CHARS-1-int'(idx)) +: 8];
			if (!((idx < KW_LEN[i]) && (kc == c)))
				r[i] = 1'b0;
		end
		return r;
	endfunction

	function automatic logic [KIND_BITS-1:0] word_kind(input logic [NUM_KW-1:0] cand,
			input logic [3:0] len);
		logic [KIND_BITS-1:0] k;
		k = K_IDENT;
		for (int i = 0; i < NUM_KW; i++)
			if (cand[i] && (KW_LEN[i] == len))
				k = K_KW0 + KIND_BITS'(i);
		return k;
	endfunction

endpackage
`default_nettype wire

### rtl/sct_in_if.sv
`default_nettype none
interface sct_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       end_of_source;

	modport source (output valid, char_code, end_of_source, input ready);
	modport sink (input valid, char_code, end_of_source, output ready);
endinterface
`default_nettype wire

### rtl/sct_out_if.sv
`default_nettype none
interface sct_out_if import sct_pkg::*; #(
	parameter int unsigned POSITION_BITS = POSITION_BITS_DEF,
	parameter int unsigned MANTISSA_BITS = MANTISSA_BITS_DEF
);
	logic                     valid;
	logic                     ready;
	logic [KIND_BITS-1:0]     token_kind;
	logic [ERR_BITS-1:0]      error_code;
	logic [POSITION_BITS-1:0] start_pos;
	logic [POSITION_BITS:0]   end_pos;
	logic [MANTISSA_BITS-1:0] number_mantissa;
	logic [FRAC_BITS-1:0]     fraction_digits;
	logic [7:0]               char_value;
	logic                     last_result;

	modport source (output valid, token_kind, error_code, start_pos, end_pos,
		number_mantissa, fraction_digits, char_value, last_result, input ready);
	modport sink (input valid, token_kind, error_code, start_pos, end_pos,
		number_mantissa, fraction_digits, char_value, last_result, output ready);
endinterface
`default_nettype wire

### rtl/sct_core.sv
`default_nettype none
module sct_core import sct_pkg::*; #(
	parameter int unsigned POSITION_BITS = POSITION_BITS_DEF,
	parameter int unsigned MANTISSA_BITS = MANTISSA_BITS_DEF,
	localparam int unsigned RW = KIND_BITS + ERR_BITS + 2*POSITION_BITS + 1 +
		MANTISSA_BITS + FRAC_BITS + 8 + 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [7:0]    in_char,
	input  wire logic          in_eos,
	input  wire logic          room,
	output logic               push_go,
	output logic [1:0]         push_n,
	output logic [RW-1:0]      push_r0,
	output logic [RW-1:0]      push_r1
);
	localparam int unsigned PB = POSITION_BITS;
	localparam int unsigned MB = MANTISSA_BITS;

	typedef enum logic [3:0] {
		M_IDLE, M_IDENT, M_NUMBER, M_DOT, M_OP, M_STAR2,
		M_CHAR_OPEN, M_CHAR_BODY, M_STRING
	} mode_t;

	logic                s1_valid;
	logic [7:0]          char_s1;
	logic                eos_s1;
	mode_t               mode_q, mode_d;
	logic [PB-1:0]       pos_q, pos_d, start_q, start_d;
	logic [7:0]          held_q, held_d, lit_q, lit_d;
	logic [MB-1:0]       mant_q, mant_d;
	logic [3:0]          frac_q, frac_d, wlen_q, wlen_d;
	logic                dot_q, dot_d;
	logic [NUM_KW-1:0]   cand_q, cand_d;
	logic [RW-1:0]       res [2];
	logic [1:0]          n;
	logic                restart;
	logic [PB:0]         p_end, p_next;

	function automatic logic [RW-1:0] pack(input logic [KIND_BITS-1:0] kind,
			input logic [ERR_BITS-1:0] err, input logic [PB-1:0] s,
			input logic [PB:0] e, input logic [MB-1:0] mant,
			input logic [3:0] frac, input logic [7:0] chv);
		return {(err != E_NONE) ? {KIND_BITS{1'b0}} : kind, err, s, e, mant, frac,
			chv, 1'b0};
	endfunction

	// Appends one digit, holding at the top value on overflow.
	function automatic logic [MB-1:0] sat_digit(input logic [MB-1:0] acc,
			input logic [7:0] c);
		logic [MB+3:0] t;
		t = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + (MB+4)'(c - CH_ZERO);
		return (t[MB+3:MB] != 4'd0) ? {MB{1'b1}} : t[MB-1:0];
	endfunction

	// The input register is free when empty or when its beat moves on.
	assign push_go  = s1_valid && room;
	assign in_ready = !s1_valid || room;
	assign p_end    = {1'b0, pos_q};
	assign p_next   = p_end + 1'b1;

	// Next state and up to two results for the byte in the input register.
	always_comb begin
		mode_d  = mode_q;
		pos_d   = pos_q;
		start_d = start_q;
		held_d  = held_q;
		lit_d   = lit_q;
		mant_d  = mant_q;
		frac_d  = frac_q;
		wlen_d  = wlen_q;
		dot_d   = dot_q;
		cand_d  = cand_q;
		res[0]  = '0;
		res[1]  = '0;
		n       = 2'd0;
		restart = 1'b0;
		if (eos_s1) begin
			// Flush whatever is pending, then close the text.
			case (mode_q)
				M_IDENT: begin
					res[n[0]] = pack(word_kind(cand_q, wlen_q), E_NONE, start_q, p_end,
						'0, 4'd0, 8'd0);
					n = n + 2'd1;
				end
				M_NUMBER: begin
					res[n[0]] = pack(dot_q ? K_FLOAT : K_INTEGER, E_NONE, start_q, p_end,
						mant_q, dot_q ? frac_q : 4'd0, 8'd0);
					n = n + 2'd1;
				end
				M_DOT: begin
					res[n[0]] = pack(K_DOT, E_NONE, start_q, p_end, '0, 4'd0, 8'd0);
					n = n + 2'd1;
				end
				M_OP: begin
					if (held_q == CH_AMP)
						res[n[0]] = pack(K_EOF, E_LONE_AMP, pos_q, p_next, '0, 4'd0, 8'd0);
					else if (held_q == CH_PIPE)
						res[n[0]] = pack(K_EOF, E_LONE_PIPE, pos_q, p_next, '0, 4'd0, 8'd0);
					else
						res[n[0]] = pack(op_base(held_q), E_NONE, start_q, p_end, '0, 4'd0,
							8'd0);
					n = n + 2'd1;
				end
				M_STAR2: begin
					res[n[0]] = pack(K_DSTAR, E_NONE, start_q, p_end, '0, 4'd0, 8'd0);
					n = n + 2'd1;
				end
				M_CHAR_OPEN: begin
					res[n[0]] = pack(K_EOF, E_CHAR_OPEN, pos_q, p_next, '0, 4'd0, 8'd0);
					n = n + 2'd1;
				end
				M_CHAR_BODY: begin
					res[n[0]] = pack(K_EOF, E_CHAR_BODY, pos_q, p_next, '0, 4'd0, 8'd0);
					n = n + 2'd1;
				end
				M_STRING: begin
					res[n[0]] = pack(K_EOF, E_STRING, pos_q, p_next, '0, 4'd0, 8'd0);
					n = n + 2'd1;
				end
				default: ;
			endcase
			res[n[0]] = pack(K_EOF, E_NONE, pos_q, p_next, '0, 4'd0, 8'd0);
			n = n + 2'd1;
			mode_d  = M_IDLE;
			pos_d   = '0;
			start_d = '0;
			held_d  = '0;
			lit_d   = '0;
			mant_d  = '0;
			frac_d  = '0;
			wlen_d  = '0;
			dot_d   = 1'b0;
			cand_d  = '0;
		end else begin
			// Finish or extend the pending token.
			case (mode_q)
				M_IDENT: begin
					if (is_alpha(char_s1) || is_digit(char_s1) || char_s1 == CH_UNDER) begin
						cand_d = word_add(cand_q, wlen_q, char_s1);
						if (wlen_q != 4'd15)
							wlen_d = wlen_q + 4'd1;
					end else begin
						res[n[0]] = pack(word_kind(cand_q, wlen_q), E_NONE, start_q, p_end,
							'0, 4'd0, 8'd0);
						n = n + 2'd1;
						mode_d  = M_IDLE;
						restart = 1'b1;
					end
				end
				M_NUMBER: begin
					if (is_digit(char_s1)) begin
						mant_d = sat_digit(mant_q, char_s1);
						if (dot_q && frac_q != 4'd15)
							frac_d = frac_q + 4'd1;
					end else if (char_s1 == CH_DOT && !dot_q) begin
						dot_d = 1'b1;
					end else begin
						res[n[0]] = pack(dot_q ? K_FLOAT : K_INTEGER, E_NONE, start_q, p_end,
							mant_q, dot_q ? frac_q : 4'd0, 8'd0);
						n = n + 2'd1;
						mode_d  = M_IDLE;
						restart = 1'b1;
					end
				end
				M_DOT: begin
					if (is_digit(char_s1)) begin
						mode_d = M_NUMBER;
						dot_d  = 1'b1;
						mant_d = sat_digit('0, char_s1);
						frac_d = 4'd1;
					end else begin
						res[n[0]] = pack(K_DOT, E_NONE, start_q, p_end, '0, 4'd0, 8'd0);
						n = n + 2'd1;
						mode_d  = M_IDLE;
						restart = 1'b1;
					end
				end
				M_OP: begin
					mode_d = M_IDLE;
					if (held_q == CH_AMP || held_q == CH_PIPE) begin
						if (char_s1 == held_q)
							res[n[0]] = pack(op_base(held_q), E_NONE, start_q, p_next, '0,
								4'd0, 8'd0);
						else
							res[n[0]] = pack(K_EOF, (held_q == CH_AMP) ? E_LONE_AMP :
								E_LONE_PIPE, pos_q, p_next, '0, 4'd0, char_s1);
						n = n + 2'd1;
					end else if (char_s1 == CH_EQUAL) begin
						res[n[0]] = pack(op_base(held_q) + 7'd1, E_NONE, start_q, p_next, '0,
							4'd0, 8'd0);
						n = n + 2'd1;
					end else if ((held_q == CH_PLUS || held_q == CH_MINUS) &&
							char_s1 == held_q) begin
						res[n[0]] = pack(op_base(held_q) + 7'd2, E_NONE, start_q, p_next, '0,
							4'd0, 8'd0);
						n = n + 2'd1;
					end else if (held_q == CH_STAR && char_s1 == CH_STAR) begin
						mode_d = M_STAR2;
					end else begin
						res[n[0]] = pack(op_base(held_q), E_NONE, start_q, p_end, '0, 4'd0,
							8'd0);
						n = n + 2'd1;
						restart = 1'b1;
					end
				end
				M_STAR2: begin
					mode_d = M_IDLE;
					if (char_s1 == CH_EQUAL) begin
						res[n[0]] = pack(K_DSTAR_EQ, E_NONE, start_q, p_next, '0, 4'd0, 8'd0);
					end else begin
						res[n[0]] = pack(K_DSTAR, E_NONE, start_q, p_end, '0, 4'd0, 8'd0);
						restart = 1'b1;
					end
					n = n + 2'd1;
				end
				M_CHAR_OPEN: begin
					lit_d  = char_s1;
					mode_d = M_CHAR_BODY;
				end
				M_CHAR_BODY: begin
					mode_d = M_IDLE;
					if (char_s1 == CH_SQUOTE)
						res[n[0]] = pack(K_CHAR, E_NONE, start_q, p_next, '0, 4'd0, lit_q);
					else
						res[n[0]] = pack(K_EOF, E_CHAR_CLOSE, pos_q, p_next, '0, 4'd0,
							char_s1);
					n = n + 2'd1;
				end
				M_STRING: begin
					if (char_s1 == CH_DQUOTE) begin
						res[n[0]] = pack(K_STRING, E_NONE, start_q, p_next, '0, 4'd0, 8'd0);
						n = n + 2'd1;
						mode_d = M_IDLE;
					end
				end
				default: begin
					mode_d  = M_IDLE;
					restart = 1'b1;
				end
			endcase

			// Begin a new token with this byte.
			if (restart) begin
				start_d = pos_q;
				if (is_space(char_s1)) begin
					mode_d = M_IDLE;
				end else if (is_digit(char_s1)) begin
					mode_d = M_NUMBER;
					dot_d  = 1'b0;
					frac_d = 4'd0;
					mant_d = sat_digit('0, char_s1);
				end else if (is_alpha(char_s1)) begin
					mode_d = M_IDENT;
					cand_d = word_add({NUM_KW{1'b1}}, 4'd0, char_s1);
					wlen_d = 4'd1;
				end else if (char_s1 == CH_DOT) begin
					mode_d = M_DOT;
				end else if (is_op(char_s1)) begin
					mode_d = M_OP;
					held_d = char_s1;
				end else if (char_s1 == CH_SQUOTE) begin
					mode_d = M_CHAR_OPEN;
				end else if (char_s1 == CH_DQUOTE) begin
					mode_d = M_STRING;
				end else if (single_kind(char_s1) != K_EOF) begin
					res[n[0]] = pack(single_kind(char_s1), E_NONE, pos_q, p_next, '0, 4'd0,
						8'd0);
					n = n + 2'd1;
				end else begin
					res[n[0]] = pack(K_EOF, E_UNKNOWN, pos_q, p_next, '0, 4'd0, char_s1);
					n = n + 2'd1;
				end
			end
			pos_d = pos_q + 1'b1;
		end
	end

	// Mark the final result of the beat.
	always_comb begin
		push_n  = n;
		push_r0 = {res[0][RW-1:1], n == 2'd1};
		push_r1 = {res[1][RW-1:1], 1'b1};
	end

	// Input register and lexer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			mode_q   <= M_IDLE;
			pos_q    <= '0;
			start_q  <= '0;
			held_q   <= '0;
			lit_q    <= '0;
			mant_q   <= '0;
			frac_q   <= '0;
			wlen_q   <= '0;
			dot_q    <= 1'b0;
			cand_q   <= '0;
			char_s1  <= '0;
			eos_s1   <= 1'b0;
		end else begin
			if (in_ready) begin
				s1_valid <= in_valid;
				char_s1  <= in_char;
				eos_s1   <= in_eos;
			end
			if (push_go) begin
				mode_q  <= mode_d;
				pos_q   <= pos_d;
				start_q <= start_d;
				held_q  <= held_d;
				lit_q   <= lit_d;
				mant_q  <= mant_d;
				frac_q  <= frac_d;
				wlen_q  <= wlen_d;
				dot_q   <= dot_d;
				cand_q  <= cand_d;
			end
		end
	end
endmodule
`default_nettype wire

### rtl/sct_result_queue.sv
`default_nettype none
module sct_result_queue #(
	parameter int unsigned RW = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push_go,
	input  wire logic [1:0]    push_n,
	input  wire logic [RW-1:0] push_r0,
	input  wire logic [RW-1:0] push_r1,
	output logic               room,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [RW-1:0]      out_data
);
	logic [RW-1:0] mem_q [4];
	logic [1:0]    wr_q, rd_q;
	logic [2:0]    cnt_q;
	logic          pop;
	logic [1:0]    n_in;

	// Room for the two results one byte may cause.
	assign room      = cnt_q <= 3'd2;
	assign out_valid = cnt_q != 3'd0;
	assign out_data  = mem_q[rd_q];
	assign pop       = out_valid && out_ready;
	assign n_in      = push_go ? push_n : 2'd0;

	always_ff @(posedge clk) begin
		if (push_go && push_n != 2'd0)
			mem_q[wr_q] <= push_r0;
		if (push_go && push_n == 2'd2)
			mem_q[wr_q + 2'd1] <= push_r1;
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + n_in;
			rd_q  <= rd_q + {1'b0, pop};
			cnt_q <= cnt_q + {1'b0, n_in} - {2'b0, pop};
		end
	end
endmodule
`default_nettype wire

### rtl/source_code_tokenizer_unit.sv
`default_nettype none
// Streaming tokenizer for source text.
// The text channel takes one byte per beat; a beat with end_of_source set
// flushes the pending token and adds an EOF token, then the block starts a
// fresh text at position zero. The tokens channel gives one token or error
// per beat with its byte span; last_result marks the final result of a byte.
// A byte causes zero, one or two results.
// A byte is decoded from the input register in the cycle after its beat is
// accepted; its results are written into the result queue and offered from there.
// Throughput: one byte per cycle while the receiver keeps up; the output
// drains one result per cycle, so bytes that make two results are limited
// by the four-entry result queue, which takes a byte only with two free slots.
// Reset clears the lexer to idle between tokens at position zero and empties
// the queue. When the receiver stalls, results wait in the queue; once the
// queue cannot hold two more, the next byte waits in the input register and
// the text channel drops ready.
module source_code_tokenizer_unit import sct_pkg::*; #(
	parameter int unsigned POSITION_BITS = POSITION_BITS_DEF,
	parameter int unsigned MANTISSA_BITS = MANTISSA_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	sct_in_if.sink   text,
	sct_out_if.source tokens
);
	localparam int unsigned RW = KIND_BITS + ERR_BITS + 2*POSITION_BITS + 1 +
		MANTISSA_BITS + FRAC_BITS + 8 + 1;

	logic          room, push_go;
	logic [1:0]    push_n;
	logic [RW-1:0] push_r0, push_r1, out_data;

	sct_core #(
		.POSITION_BITS(POSITION_BITS),
		.MANTISSA_BITS(MANTISSA_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (text.valid),
		.in_ready (text.ready),
		.in_char  (text.char_code),
		.in_eos   (text.end_of_source),
		.room     (room),
		.push_go  (push_go),
		.push_n   (push_n),
		.push_r0  (push_r0),
		.push_r1  (push_r1)
	);

	sct_result_queue #(
		.RW(RW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_go   (push_go),
		.push_n    (push_n),
		.push_r0   (push_r0),
		.push_r1   (push_r1),
		.room      (room),
		.out_valid (tokens.valid),
		.out_ready (tokens.ready),
		.out_data  (out_data)
	);

	// Unpack the queued result onto the channel fields.
	assign {tokens.token_kind, tokens.error_code, tokens.start_pos, tokens.end_pos,
		tokens.number_mantissa, tokens.fraction_digits, tokens.char_value,
		tokens.last_result} = out_data;
endmodule
`default_nettype wire
